### hw/rtl/acps_pkg.sv
// Package for the capsule pixel shader: constants, stage map, stage types, helpers.
`default_nettype none

package acps_pkg;

    localparam int FB_WIDTH        = 256;
    localparam int FB_HEIGHT       = 256;
    localparam int COORD_FRAC_BITS = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // restoring divider: one quotient bit per stage
    localparam int DIV_STEPS = 16;
    // square root of q2 << 32: one root bit per stage
    localparam int SQ_STEPS  = 29;
    localparam int RAD_PAIRS = 13;

    // stage map
    localparam int ST_SUB     = 0;
    localparam int ST_MUL     = 1;
    localparam int ST_NUM     = 2;
    localparam int ST_TMUL    = ST_NUM + DIV_STEPS + 1;
    localparam int ST_Q       = ST_TMUL + 1;
    localparam int ST_SQ      = ST_Q + 1;
    localparam int ST_CMP     = ST_SQ + 1;
    localparam int ST_COV     = ST_CMP + SQ_STEPS + 1;
    localparam int ST_ALPHA   = ST_COV + 1;
    localparam int ST_BLEND   = ST_ALPHA + 1;
    localparam int ST_OUT     = ST_BLEND + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEG_START_X  = 3'd0,
        CFG_SEG_START_Y  = 3'd1,
        CFG_SEG_END_X    = 3'd2,
        CFG_SEG_END_Y    = 3'd3,
        CFG_STROKE_RAD   = 3'd4,
        CFG_STROKE_COLOR = 3'd5,
        CFG_STROKE_ALPHA = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [16:0] ax;
        logic [16:0] ay;
        logic [16:0] dx;
        logic [16:0] dy;
        logic [32:0] den;
        logic [32:0] rem;
        logic [15:0] quo;
        logic        sat_lo;
        logic        sat_hi;
        logic [15:0] old;
        logic        oob;
    } t_div_stg;

    typedef struct packed {
        logic [25:0] rad;
        logic [30:0] rem;
        logic [28:0] root;
        logic        full;
        logic        none;
        logic        oob;
        logic [15:0] old;
    } t_sq_stg;

    // floor(x / 255), exact for x < 2^16 - 1
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [17:0] s;
        s = {1'b0, x} + {9'd0, x[16:8]} + 18'd1;
        return s[16:8];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/antialiased_capsule_pixel_shader.sv
// Throughput: one pixel per clock while m_axis_tready is high; every stage
// has its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles collapse. The divider (16 stages) and the square root
// (29 stages) set the depth. Reset (synchronous, active low) empties the pipe
// and loads the register defaults: all zero except stroke_alpha = 255.
`default_nettype none

module antialiased_capsule_pixel_shader
    import acps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] pixel_x, [15:8] pixel_y, [31:16] old_color
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] new_color, [23:16] coverage
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] pixel_written
    output logic [0:0]            m_axis_tuser
);

    localparam logic [11:0] HALF_PIX = 12'(1 << (COORD_FRAC_BITS - 1));

    // configuration
    logic [15:0] r_seg_start_x, r_seg_start_y, r_seg_end_x, r_seg_end_y;
    logic [11:0] r_stroke_radius;
    logic [15:0] r_stroke_color;
    logic [7:0]  r_stroke_alpha;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_start_x   <= '0;
            r_seg_start_y   <= '0;
            r_seg_end_x     <= '0;
            r_seg_end_y     <= '0;
            r_stroke_radius <= '0;
            r_stroke_color  <= '0;
            r_stroke_alpha  <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SEG_START_X:  r_seg_start_x   <= i_cfg_data;
                CFG_SEG_START_Y:  r_seg_start_y   <= i_cfg_data;
                CFG_SEG_END_X:    r_seg_end_x     <= i_cfg_data;
                CFG_SEG_END_Y:    r_seg_end_y     <= i_cfg_data;
                CFG_STROKE_RAD:   r_stroke_radius <= i_cfg_data[11:0];
                CFG_STROKE_COLOR: r_stroke_color  <= i_cfg_data;
                CFG_STROKE_ALPHA: r_stroke_alpha  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // valid bits and per-stage load enables
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] w_en;

    assign w_en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || m_axis_tready;
    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= s_axis_tvalid;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign s_axis_tready = w_en[0];

    // stage: offsets from the segment start
    logic [7:0]  w_px, w_py;
    logic [16:0] n_ax, n_ay, n_dx, n_dy;
    logic        n_oob;
    logic [16:0] r_sb_ax, r_sb_ay, r_sb_dx, r_sb_dy;
    logic [15:0] r_sb_old;
    logic        r_sb_oob;

    assign w_px  = s_axis_tdata[7:0];
    assign w_py  = s_axis_tdata[15:8];
    assign n_ax  = ({9'd0, w_px} << COORD_FRAC_BITS) - {r_seg_start_x[15], r_seg_start_x};
    assign n_ay  = ({9'd0, w_py} << COORD_FRAC_BITS) - {r_seg_start_y[15], r_seg_start_y};
    assign n_dx  = {r_seg_end_x[15], r_seg_end_x} - {r_seg_start_x[15], r_seg_start_x};
    assign n_dy  = {r_seg_end_y[15], r_seg_end_y} - {r_seg_start_y[15], r_seg_start_y};
    assign n_oob = ({5'd0, w_px} >= 13'(FB_WIDTH)) || ({5'd0, w_py} >= 13'(FB_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUB]) begin
            r_sb_ax  <= n_ax;
            r_sb_ay  <= n_ay;
            r_sb_dx  <= n_dx;
            r_sb_dy  <= n_dy;
            r_sb_old <= s_axis_tdata[31:16];
            r_sb_oob <= n_oob;
        end
    end

    // stage: dot products
    logic signed [33:0] r_ml_axdx, r_ml_aydy, r_ml_dxdx, r_ml_dydy;
    logic [16:0] r_ml_ax, r_ml_ay, r_ml_dx, r_ml_dy;
    logic [15:0] r_ml_old;
    logic        r_ml_oob;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            r_ml_axdx <= $signed(r_sb_ax) * $signed(r_sb_dx);
            r_ml_aydy <= $signed(r_sb_ay) * $signed(r_sb_dy);
            r_ml_dxdx <= $signed(r_sb_dx) * $signed(r_sb_dx);
            r_ml_dydy <= $signed(r_sb_dy) * $signed(r_sb_dy);
            r_ml_ax   <= r_sb_ax;
            r_ml_ay   <= r_sb_ay;
            r_ml_dx   <= r_sb_dx;
            r_ml_dy   <= r_sb_dy;
            r_ml_old  <= r_sb_old;
            r_ml_oob  <= r_sb_oob;
        end
    end

    // stage: projection numerator and length, divider setup
    t_div_stg r_div [DIV_STEPS+1];
    logic signed [33:0] w_num;
    logic [33:0]        w_len2;
    t_div_stg           n_div0;

    assign w_num  = r_ml_axdx + r_ml_aydy;
    assign w_len2 = r_ml_dxdx + r_ml_dydy;

    always_comb begin
        n_div0        = '0;
        n_div0.ax     = r_ml_ax;
        n_div0.ay     = r_ml_ay;
        n_div0.dx     = r_ml_dx;
        n_div0.dy     = r_ml_dy;
        n_div0.den    = w_len2[32:0];
        n_div0.old    = r_ml_old;
        n_div0.oob    = r_ml_oob;
        // zero-length segment gives num == 0, so it lands here too
        n_div0.sat_lo = w_num[33] || (w_num == 34'sd0);
        n_div0.sat_hi = !n_div0.sat_lo && (w_num[32:0] >= w_len2[32:0]);
        n_div0.rem    = (n_div0.sat_lo || n_div0.sat_hi) ? 33'd0 : w_num[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NUM]) r_div[0] <= n_div0;
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        logic [33:0] w_r2;
        logic [33:0] w_sub;
        logic        w_ge;
        t_div_stg    n_div;

        assign w_r2  = {r_div[i].rem, 1'b0};
        assign w_sub = w_r2 - {1'b0, r_div[i].den};
        assign w_ge  = w_r2 >= {1'b0, r_div[i].den};

        always_comb begin
            n_div     = r_div[i];
            n_div.rem = w_ge ? w_sub[32:0] : w_r2[32:0];
            n_div.quo = {r_div[i].quo[14:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_NUM+i+1]) r_div[i+1] <= n_div;
        end
    end

    // stage: t * d
    logic [16:0]        w_t;
    logic signed [34:0] r_tm_tdx, r_tm_tdy;
    logic [16:0]        r_tm_ax, r_tm_ay;
    logic [15:0]        r_tm_old;
    logic               r_tm_oob;

    always_comb begin
        priority if (r_div[DIV_STEPS].sat_hi) w_t = 17'h10000;
        else if (r_div[DIV_STEPS].sat_lo)     w_t = 17'd0;
        else                                  w_t = {1'b0, r_div[DIV_STEPS].quo};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_TMUL]) begin
            r_tm_tdx <= $signed({1'b0, w_t}) * $signed(r_div[DIV_STEPS].dx);
            r_tm_tdy <= $signed({1'b0, w_t}) * $signed(r_div[DIV_STEPS].dy);
            r_tm_ax  <= r_div[DIV_STEPS].ax;
            r_tm_ay  <= r_div[DIV_STEPS].ay;
            r_tm_old <= r_div[DIV_STEPS].old;
            r_tm_oob <= r_div[DIV_STEPS].oob;
        end
    end

    // stage: offset to the nearest point, rounded half up
    logic signed [34:0] w_bx, w_by, w_rx, w_ry;
    logic [19:0]        n_qx, n_qy;
    logic [19:0]        r_q_qx, r_q_qy;
    logic [15:0]        r_q_old;
    logic               r_q_oob;

    assign w_bx = r_tm_tdx + 35'sd32768;
    assign w_by = r_tm_tdy + 35'sd32768;
    assign w_rx = w_bx >>> 16;
    assign w_ry = w_by >>> 16;
    assign n_qx = {{3{r_tm_ax[16]}}, r_tm_ax} - w_rx[19:0];
    assign n_qy = {{3{r_tm_ay[16]}}, r_tm_ay} - w_ry[19:0];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_Q]) begin
            r_q_qx  <= n_qx;
            r_q_qy  <= n_qy;
            r_q_old <= r_tm_old;
            r_q_oob <= r_tm_oob;
        end
    end

    // stage: squares of offsets and of the band edges
    logic [11:0] w_rin;
    logic [12:0] w_rout;
    logic [39:0] r_sq_qxx, r_sq_qyy;
    logic [23:0] r_sq_rin2;
    logic [25:0] r_sq_rout2;
    logic [15:0] r_sq_old;
    logic        r_sq_oob;

    assign w_rin  = (r_stroke_radius > HALF_PIX) ? (r_stroke_radius - HALF_PIX) : 12'd0;
    assign w_rout = {1'b0, r_stroke_radius} + {1'b0, HALF_PIX};

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SQ]) begin
            r_sq_qxx   <= $signed(r_q_qx) * $signed(r_q_qx);
            r_sq_qyy   <= $signed(r_q_qy) * $signed(r_q_qy);
            r_sq_rin2  <= w_rin * w_rin;
            r_sq_rout2 <= w_rout * w_rout;
            r_sq_old   <= r_q_old;
            r_sq_oob   <= r_q_oob;
        end
    end

    // stage: band test, square root setup
    t_sq_stg     r_sq [SQ_STEPS+1];
    logic [39:0] w_q2;
    t_sq_stg     n_sq0;

    assign w_q2 = r_sq_qxx + r_sq_qyy;

    always_comb begin
        n_sq0      = '0;
        n_sq0.rad  = w_q2[25:0];
        n_sq0.full = w_q2 <= {16'd0, r_sq_rin2};
        n_sq0.none = w_q2 >= {14'd0, r_sq_rout2};
        n_sq0.oob  = r_sq_oob;
        n_sq0.old  = r_sq_old;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_CMP]) r_sq[0] <= n_sq0;
    end

    // floor(sqrt(q2 << 32)); the low 16 radicand pairs are zero
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [1:0]  w_pair;
        logic [32:0] w_rem, w_trial, w_sub;
        logic        w_ge;
        t_sq_stg     n_sq;

        if (j < RAD_PAIRS) begin : g_hi
            assign w_pair = r_sq[j].rad[2*(RAD_PAIRS-1-j) +: 2];
        end else begin : g_lo
            assign w_pair = 2'b00;
        end

        assign w_rem   = {r_sq[j].rem, w_pair};
        assign w_trial = {2'b00, r_sq[j].root, 2'b01};
        assign w_sub   = w_rem - w_trial;
        assign w_ge    = w_rem >= w_trial;

        always_comb begin
            n_sq      = r_sq[j];
            n_sq.rem  = w_ge ? w_sub[30:0] : w_rem[30:0];
            n_sq.root = {r_sq[j].root[27:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_CMP+j+1]) r_sq[j+1] <= n_sq;
        end
    end

    // stage: coverage
    logic [28:0] w_diff;
    logic [36:0] w_prod;
    logic [14:0] w_band;
    logic [7:0]  n_cov;
    logic [7:0]  r_cv_cov;
    logic [15:0] r_cv_old;

    assign w_diff = {w_rout, 16'd0} - r_sq[SQ_STEPS].root;
    assign w_prod = {w_diff, 8'd0} - {8'd0, w_diff};
    assign w_band = 15'(w_prod >> (COORD_FRAC_BITS + 16));

    always_comb begin
        priority if (r_sq[SQ_STEPS].oob)  n_cov = 8'd0;
        else if (r_sq[SQ_STEPS].full)     n_cov = 8'd255;
        else if (r_sq[SQ_STEPS].none)     n_cov = 8'd0;
        else if (w_band > 15'd255)        n_cov = 8'd255;
        else                              n_cov = w_band[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_COV]) begin
            r_cv_cov <= n_cov;
            r_cv_old <= r_sq[SQ_STEPS].old;
        end
    end

    // stage: effective alpha
    logic [15:0] w_ca;
    logic [16:0] w_cax;
    logic [8:0]  w_a;
    logic [7:0]  r_al_a, r_al_cov;
    logic [15:0] r_al_old;

    assign w_ca  = r_cv_cov * r_stroke_alpha;
    assign w_cax = {1'b0, w_ca} + 17'd127;
    assign w_a   = div255(w_cax);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ALPHA]) begin
            r_al_a   <= w_a[7:0];
            r_al_cov <= r_cv_cov;
            r_al_old <= r_cv_old;
        end
    end

    // stage: channel mix sums
    logic [7:0]  w_ia;
    logic [13:0] n_mr, n_mg, n_mb;
    logic [13:0] r_bl_mr, r_bl_mg, r_bl_mb;
    logic        r_bl_opaque;
    logic [7:0]  r_bl_cov;
    logic [15:0] r_bl_old;

    assign w_ia = 8'd255 - r_al_a;
    assign n_mr = {9'd0, r_al_old[15:11]} * {6'd0, w_ia}
                + {9'd0, r_stroke_color[15:11]} * {6'd0, r_al_a} + 14'd127;
    assign n_mg = {8'd0, r_al_old[10:5]} * {6'd0, w_ia}
                + {8'd0, r_stroke_color[10:5]} * {6'd0, r_al_a} + 14'd127;
    assign n_mb = {9'd0, r_al_old[4:0]} * {6'd0, w_ia}
                + {9'd0, r_stroke_color[4:0]} * {6'd0, r_al_a} + 14'd127;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_BLEND]) begin
            r_bl_mr     <= n_mr;
            r_bl_mg     <= n_mg;
            r_bl_mb     <= n_mb;
            r_bl_opaque <= r_al_a == 8'd255;
            r_bl_cov    <= r_al_cov;
            r_bl_old    <= r_al_old;
        end
    end

    // output register
    logic [8:0]  w_dr, w_dg, w_db;
    logic [15:0] n_color;
    logic [15:0] r_out_color;
    logic [7:0]  r_out_cov;
    logic        r_out_wr;

    assign w_dr = div255({3'd0, r_bl_mr});
    assign w_dg = div255({3'd0, r_bl_mg});
    assign w_db = div255({3'd0, r_bl_mb});

    always_comb begin
        priority if (r_bl_cov == 8'd0) n_color = r_bl_old;
        else if (r_bl_opaque)          n_color = r_stroke_color;
        else                           n_color = {w_dr[4:0], w_dg[5:0], w_db[4:0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_out_color <= n_color;
            r_out_cov   <= r_bl_cov;
            r_out_wr    <= r_bl_cov != 8'd0;
        end
    end

    assign m_axis_tvalid   = r_v[ST_OUT];
    assign m_axis_tdata    = {r_out_cov, r_out_color};
    assign m_axis_tuser[0] = r_out_wr;

`ifndef SYNTHESIS
    a_written_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[23:16] != 8'd0)))
        else $error("pixel_written disagrees with coverage");

    a_uncovered_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_BLEND] && w_en[ST_OUT] && r_bl_cov == 8'd0)
        |=> (m_axis_tdata[15:0] == $past(r_bl_old)))
        else $error("uncovered pixel changed color");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[ST_SUB])
        else $error("accepted request not captured");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_SUB] && !w_en[ST_SUB]) |=> r_v[ST_SUB])
        else $error("stalled first stage dropped its request");

    a_band_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_CMP] |-> !(r_sq[0].full && r_sq[0].none))
        else $error("inside and outside flags both set");
`endif

endmodule

`default_nettype wire
